>>> rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  // result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam int MaxRes = 3;
  localparam int HexDigits = 4;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  // results of one decoded byte
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MaxRes-1:0]     res;
  } dec_t;

endpackage
`default_nettype wire

>>> rtl/json_string_unescape.sv
`default_nettype none
// JSON string unescaper with UTF-8 output. Feed the raw bytes of one quoted
// string, opening quote first; out_tuser tells a decoded byte (0), a clean
// close (1) or a syntax error (2), and out_tlast marks the final result of an
// input byte. Escapes \t \n \r \\ \" \/ \b \f and \uXXXX are decoded; code
// points go out as one to three UTF-8 bytes, surrogates are not paired. After
// an error the block waits for a new opening quote. Rate: one input byte per
// cycle while out_tready holds; the single result register sends one result
// per cycle, so a \u escape that yields two or three bytes holds the input
// until its last result is taken. A byte passes the input register, then the
// result group register. in_tready is registered, from a one-entry skid stage.
module json_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_data
  output logic [1:0]      out_tuser,  // [1:0] kind
  output logic            out_tlast
);

  logic [7:0] byte_r, skid_r;
  logic       vld_r, skid_vld_r;
  logic       in_acc, out_acc, consume, grp_free, grp_done;

  jsu_pkg::dec_t              dec;
  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0] grp_r;
  logic [1:0]                 cnt_r, idx_r;
  logic                       grp_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign grp_done  = (idx_r == cnt_r - 2'd1);
  assign grp_free  = !grp_vld_r || (out_tready && grp_done);
  assign consume   = vld_r && grp_free;

  // input register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (consume || !vld_r) begin
      if (skid_vld_r) begin
        vld_r      <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        vld_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume || !vld_r) begin
      byte_r <= skid_vld_r ? skid_r : in_tdata;
    end
    if (in_acc && vld_r && !consume) begin
      skid_r <= in_tdata;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .in_byte (byte_r),
    .dec     (dec)
  );

  // result group register, drained one result per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      cnt_r     <= 2'd0;
    end else if (consume && dec.cnt != 2'd0) begin
      grp_vld_r <= 1'b1;
      idx_r     <= 2'd0;
      cnt_r     <= dec.cnt;
    end else if (out_acc) begin
      if (grp_done) begin
        grp_vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && dec.cnt != 2'd0) begin
      grp_r <= dec.res;
    end
  end

  assign out_tvalid = grp_vld_r;
  assign out_tdata  = grp_r[idx_r].data;
  assign out_tuser  = grp_r[idx_r].kind;
  assign out_tlast  = grp_done;

  // skid holds data only behind a full input register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> vld_r)
    else $error("skid full with empty input register");

  // a shown result is inside its group
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt_r != 2'd0 && idx_r < cnt_r))
    else $error("result index outside group");

  // a byte with results puts a group on the output next cycle
  a_grp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && dec.cnt != 2'd0) |=> (out_tvalid && idx_r == 2'd0))
    else $error("result group not loaded");

endmodule
`default_nettype wire

>>> rtl/jsu_decode.sv
`default_nettype none
// Parser state and byte decode: one byte per step, up to three results out.
module jsu_decode (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   in_byte,
  output jsu_pkg::dec_t     dec
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      hex_count_r, hex_count_nxt;
  logic [15:0]     code_r, code_nxt;

  logic            is_hex;
  logic [3:0]      hex_v;
  logic [15:0]     cp;

  // hex digit value
  always_comb begin
    is_hex = 1'b1;
    hex_v  = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_v = 4'(in_byte - 8'h30);
    end else if (in_byte inside {[8'h61:8'h66]}) begin
      hex_v = 4'(in_byte - 8'h57);
    end else if (in_byte inside {[8'h41:8'h46]}) begin
      hex_v = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cp = {code_r[11:0], hex_v};

  // next state and results
  always_comb begin
    phase_nxt     = phase_r;
    hex_count_nxt = hex_count_r;
    code_nxt      = code_r;
    dec           = '0;
    dec.res[0].kind = jsu_pkg::KIND_DATA;
    dec.res[1].kind = jsu_pkg::KIND_DATA;
    dec.res[2].kind = jsu_pkg::KIND_DATA;
    case (phase_r)
      jsu_pkg::PH_WAIT: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          phase_nxt = jsu_pkg::PH_BODY;
        end else begin
          dec.cnt         = 2'd1;
          dec.res[0].kind = jsu_pkg::KIND_ERR;
        end
      end
      jsu_pkg::PH_BODY: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          dec.cnt         = 2'd1;
          dec.res[0].kind = jsu_pkg::KIND_END;
          phase_nxt       = jsu_pkg::PH_WAIT;
        end else if (in_byte == jsu_pkg::CH_BSL) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else begin
          dec.cnt         = 2'd1;
          dec.res[0].data = in_byte;
        end
      end
      jsu_pkg::PH_ESC: begin
        dec.cnt   = 2'd1;
        phase_nxt = jsu_pkg::PH_BODY;
        case (in_byte)
          jsu_pkg::CH_T:     dec.res[0].data = 8'h09;
          jsu_pkg::CH_N:     dec.res[0].data = 8'h0A;
          jsu_pkg::CH_R:     dec.res[0].data = 8'h0D;
          jsu_pkg::CH_B:     dec.res[0].data = 8'h08;
          jsu_pkg::CH_F:     dec.res[0].data = 8'h0C;
          jsu_pkg::CH_BSL:   dec.res[0].data = jsu_pkg::CH_BSL;
          jsu_pkg::CH_QUOTE: dec.res[0].data = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_SLASH: dec.res[0].data = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_U: begin
            dec.cnt       = 2'd0;
            phase_nxt     = jsu_pkg::PH_HEX;
            hex_count_nxt = 3'd0;
            code_nxt      = 16'd0;
          end
          default: begin
            dec.res[0].kind = jsu_pkg::KIND_ERR;
            phase_nxt       = jsu_pkg::PH_WAIT;
          end
        endcase
      end
      default: begin
        if (is_hex && hex_count_r < 3'(jsu_pkg::HexDigits)) begin
          code_nxt      = cp;
          hex_count_nxt = hex_count_r + 3'd1;
          // fourth digit: emit the code point as UTF-8
          if (hex_count_r == 3'(jsu_pkg::HexDigits - 1)) begin
            phase_nxt = jsu_pkg::PH_BODY;
            if (cp <= 16'h007F) begin
              dec.cnt         = 2'd1;
              dec.res[0].data = cp[7:0];
            end else if (cp <= 16'h07FF) begin
              dec.cnt         = 2'd2;
              dec.res[0].data = {3'b110, cp[10:6]};
              dec.res[1].data = {2'b10, cp[5:0]};
            end else begin
              dec.cnt         = 2'd3;
              dec.res[0].data = {4'b1110, cp[15:12]};
              dec.res[1].data = {2'b10, cp[11:6]};
              dec.res[2].data = {2'b10, cp[5:0]};
            end
          end
        end else begin
          dec.cnt         = 2'd1;
          dec.res[0].kind = jsu_pkg::KIND_ERR;
          phase_nxt       = jsu_pkg::PH_WAIT;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jsu_pkg::PH_WAIT;
      hex_count_r <= 3'd0;
      code_r      <= 16'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      hex_count_r <= hex_count_nxt;
      code_r      <= code_nxt;
    end
  end

  // the digit count never passes four
  a_hex_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    hex_count_r <= 3'(jsu_pkg::HexDigits))
    else $error("hex digit count out of range");

  // after a u escape the collection starts empty
  a_hex_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == jsu_pkg::PH_ESC && in_byte == jsu_pkg::CH_U)
      |=> (phase_r == jsu_pkg::PH_HEX && hex_count_r == 3'd0 && code_r == 16'd0))
    else $error("hex collection not cleared");

endmodule
`default_nettype wire
